// ===== design/sst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, codes and defaults of the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         position;
        logic [6:0]         count;
        logic signed [31:0] total;
    } rsp_t;

    // request wavefront moving down the cell row
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
        logic               decided;   // first entry not below value seen
        logic               found;     // value is held
        logic               shift;     // entries are being moved
        logic signed [31:0] carry;     // entry displaced by an insert
    } wave_t;

endpackage

// ===== design/sst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted row: holds one entry and acts on the request
// wavefront as it passes, then hands it to the next slot.
// ----------------------------------------------------------------------------
module sst_cell #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF,
    parameter int IDX      = 0,
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int PW      = $clog2(CAPACITY)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CW-1:0]       occ,
    input  logic                tok_in,
    input  sst_pkg::wave_t      wave_in,
    input  logic [PW-1:0]       pos_in,
    input  logic signed [31:0]  nb_elem,
    output logic signed [31:0]  elem,
    output logic                tok_out,
    output sst_pkg::wave_t      wave_out,
    output logic [PW-1:0]       pos_out
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [31:0] elem_reg;
    logic signed [31:0] elem_next;
    logic               elem_we;
    logic               tok_reg;
    sst_pkg::wave_t     wave_reg;
    sst_pkg::wave_t     wave_next;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    logic               slot_valid;
    logic               is_ins;
    logic               is_del;
    logic               full;

    assign slot_valid = IDX_C < occ;
    assign is_ins     = wave_in.mode == sst_pkg::MODE_INSERT;
    assign is_del     = wave_in.mode == sst_pkg::MODE_DELETE;
    assign full       = occ == CAP_C;

    always_comb
    begin
        wave_next = wave_in;
        pos_next  = pos_in;
        elem_next = elem_reg;
        elem_we   = 1'b0;
        if (tok_in)
        begin
            if (!wave_in.decided)
            begin
                if (slot_valid && (elem_reg < wave_in.value))
                begin
                    // smaller entry, keep going
                end
                else if (slot_valid && (elem_reg == wave_in.value))
                begin
                    wave_next.decided = 1'b1;
                    wave_next.found   = 1'b1;
                    pos_next          = PW'(IDX);
                    if (is_del)
                    begin
                        wave_next.shift = 1'b1;
                        elem_next       = nb_elem;
                        elem_we         = 1'b1;
                    end
                end
                else
                begin
                    // empty slot or larger entry: value is absent
                    wave_next.decided = 1'b1;
                    if (is_ins && !full)
                    begin
                        wave_next.shift = 1'b1;
                        wave_next.carry = elem_reg;
                        pos_next        = PW'(IDX);
                        elem_next       = wave_in.value;
                        elem_we         = 1'b1;
                    end
                end
            end
            else if (wave_in.shift)
            begin
                if (is_ins && (IDX_C <= occ))
                begin
                    wave_next.carry = elem_reg;
                    elem_next       = wave_in.carry;
                    elem_we         = 1'b1;
                end
                else if (is_del && slot_valid)
                begin
                    elem_next = nb_elem;
                    elem_we   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_reg <= elem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg <= wave_next;
        pos_reg  <= pos_next;
    end

    assign elem     = elem_reg;
    assign tok_out  = tok_reg;
    assign wave_out = wave_reg;
    assign pos_out  = pos_reg;

endmodule

// ===== design/sorted_set_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table_unit
// Sorted set of distinct signed 32-bit values with lookup, insert and delete,
// built as a row of slots that a request wavefront walks through.
// ----------------------------------------------------------------------------
//
//  channel   ports                  transfer when
//  -------   --------------------   ------------------------------
//  request   start, busy, req       start high and busy low
//  result    done, rsp              done high (one cycle, no stall)
//
//  every request is carried by the wavefront advancing one slot per cycle
//  through every slot of the row, with no stall, before done; busy drops
//  together with done, so the next request can be taken in the cycle done
//  is shown
//  reset empties the set (count and total zero); slot contents need no reset
//  results cannot be stalled by the receiver
//
module sorted_set_table_unit #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sst_pkg::req_t req,
    output logic          done,
    output sst_pkg::rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // slot row links
    logic               tok_w  [CAPACITY+1];
    sst_pkg::wave_t     wave_w [CAPACITY+1];
    logic [PW-1:0]      pos_w  [CAPACITY+1];
    logic signed [31:0] elem_w [CAPACITY];

    logic               accept;
    logic               busy_reg;
    logic               busy_next;
    logic [CW-1:0]      occ_reg;
    logic [CW-1:0]      occ_next;
    logic signed [31:0] sum_reg;
    logic signed [31:0] sum_next;
    logic               done_reg;
    sst_pkg::rsp_t      rsp_reg;
    sst_pkg::rsp_t      rsp_next;
    sst_pkg::wave_t     wave_last;
    logic               tok_last;

    assign accept = start && !busy_reg;

    // wavefront injected into the first slot at transfer
    assign tok_w[0]          = accept;
    assign wave_w[0].mode    = req.mode;
    assign wave_w[0].value   = req.value;
    assign wave_w[0].decided = 1'b0;
    assign wave_w[0].found   = 1'b0;
    assign wave_w[0].shift   = 1'b0;
    assign wave_w[0].carry   = '0;
    assign pos_w[0]          = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_slot
        logic signed [31:0] nb;
        // last slot has no right neighbor; its own entry falls out of range
        if (i == CAPACITY - 1)
        begin : g_tail
            assign nb = elem_w[i];
        end
        else
        begin : g_mid
            assign nb = elem_w[i+1];
        end

        sst_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .occ      (occ_reg),
            .tok_in   (tok_w[i]),
            .wave_in  (wave_w[i]),
            .pos_in   (pos_w[i]),
            .nb_elem  (nb),
            .elem     (elem_w[i]),
            .tok_out  (tok_w[i+1]),
            .wave_out (wave_w[i+1]),
            .pos_out  (pos_w[i+1])
        );
    end

    assign tok_last  = tok_w[CAPACITY];
    assign wave_last = wave_w[CAPACITY];

    // wrap-up once the wavefront leaves the row
    always_comb
    begin
        occ_next = occ_reg;
        sum_next = sum_reg;
        rsp_next.position = 6'(pos_w[CAPACITY]);
        case (wave_last.mode)
            sst_pkg::MODE_INSERT:
            begin
                if (wave_last.found)
                begin
                    rsp_next.status = sst_pkg::ST_NOCHANGE;
                end
                else if (wave_last.shift)
                begin
                    rsp_next.status = sst_pkg::ST_OK;
                    occ_next        = occ_reg + CW'(1);
                    sum_next        = sum_reg + wave_last.value;
                end
                else
                begin
                    rsp_next.status = sst_pkg::ST_FULL;
                end
            end
            sst_pkg::MODE_DELETE:
            begin
                if (wave_last.found)
                begin
                    rsp_next.status = sst_pkg::ST_OK;
                    occ_next        = occ_reg - CW'(1);
                    sum_next        = sum_reg - wave_last.value;
                end
                else
                begin
                    rsp_next.status = sst_pkg::ST_NOCHANGE;
                end
            end
            default:
            begin
                // lookup, and the unused code handled as lookup
                rsp_next.status = wave_last.found ? sst_pkg::ST_OK : sst_pkg::ST_NOCHANGE;
            end
        endcase
        rsp_next.count = 7'(occ_next);
        rsp_next.total = sum_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tok_last)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            occ_reg  <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= tok_last;
            if (tok_last)
            begin
                occ_reg <= occ_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_last)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef ASSERT_OFF
    // a taken request keeps the unit busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after request transfer");

    // result strobe frees the unit in the same cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high with result strobe");

    // element count never exceeds the store size
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_C)
        else $error("occupancy beyond capacity");

    // reported count matches the held count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.count == 7'(occ_reg)))
        else $error("reported count differs from occupancy");

    // a refused insert only happens with a full store
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == sst_pkg::ST_FULL)) |-> (occ_reg == CAP_C))
        else $error("full status with free slots");
`endif

endmodule

// ===== bench/sst_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_set_checker
// Watches the request and result channels of the sorted set table, keeps its
// own copy of the sorted set and compares every result with the prediction.
// ----------------------------------------------------------------------------
module sst_set_checker #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  sst_pkg::req_t req,
    input  logic          done,
    input  sst_pkg::rsp_t rsp,
    output int            errors,
    output int            outstanding
);

    logic signed [31:0] held [CAPACITY];
    int                 held_cnt;
    logic [31:0]        held_sum;
    sst_pkg::rsp_t      awaited_rsp [$];
    int                 fault_total = 0;

    assign errors = fault_total;

    // applies one request to the shadow set and returns the response it earns
    function automatic sst_pkg::rsp_t set_update(input sst_pkg::req_t r);
        sst_pkg::rsp_t      o;
        int                 idx;
        int                 k;
        bit                 present;
        logic signed [31:0] v;
        v   = $signed(r.value);
        idx = 0;
        while (idx < held_cnt && held[idx] < v)
            idx++;
        present    = (idx < held_cnt) && (held[idx] == v);
        o.status   = sst_pkg::ST_NOCHANGE;
        o.position = '0;
        case (r.mode)
            sst_pkg::MODE_INSERT:
            begin
                if (present)
                    o.position = idx[5:0];
                else if (held_cnt >= CAPACITY)
                    o.status = sst_pkg::ST_FULL;
                else
                begin
                    for (k = held_cnt; k > idx; k--)
                        held[k] = held[k - 1];
                    held[idx]  = v;
                    held_cnt++;
                    held_sum   = held_sum + v;
                    o.status   = sst_pkg::ST_OK;
                    o.position = idx[5:0];
                end
            end
            sst_pkg::MODE_DELETE:
            begin
                if (present)
                begin
                    for (k = idx; k + 1 < held_cnt; k++)
                        held[k] = held[k + 1];
                    held_cnt--;
                    held_sum   = held_sum - v;
                    o.status   = sst_pkg::ST_OK;
                    o.position = idx[5:0];
                end
            end
            default:
            begin
                // lookup, spare mode code included
                if (present)
                begin
                    o.status   = sst_pkg::ST_OK;
                    o.position = idx[5:0];
                end
            end
        endcase
        o.count = held_cnt[6:0];
        o.total = held_sum;
        return o;
    endfunction

    task automatic compare_field(input string fname, input logic signed [32:0] want,
                                 input logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            fault_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sst_pkg::rsp_t want;
        if (!rst_n)
        begin
            held_cnt = 0;
            held_sum = '0;
            awaited_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            // result first: a new transfer may share the edge with done
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fault_total++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    compare_field("status", 33'(want.status), 33'(rsp.status));
                    compare_field("position", 33'(want.position), 33'(rsp.position));
                    compare_field("count", 33'(want.count), 33'(rsp.count));
                    compare_field("total", 33'($signed(want.total)),
                                  33'($signed(rsp.total)));
                end
            end
            if (start && !busy)
                awaited_rsp.push_back(set_update(req));
            outstanding <= awaited_rsp.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives lookup, insert and delete requests into the sorted set table with
// random pacing; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         CAPACITY     = sst_pkg::CAPACITY_DEF;
    localparam int         RANDOM_ITEMS = 800;
    localparam int         PHASE_LEN    = 150;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    // unused mode code, the block treats it as a lookup
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 2;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    sst_pkg::req_t  req   = '0;
    logic           busy;
    logic           done;
    sst_pkg::rsp_t  rsp;
    int             errors;
    int             outstanding;
    int             cycle_cnt = 0;
    bit             steady    = 1'b0;

    // values inserted so far and not yet picked for a delete, so that lookups,
    // deletes and repeated inserts hit entries the set actually holds
    logic signed [31:0] recent_vals [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sorted_set_table_unit #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    sst_set_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // watchdog: a hung handshake must not stall the run forever
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short pauses, a few long ones that can outlast a whole request
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 0;
        else if (sel < 85)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // value source: pool of held values, small values that collide often,
    // field extremes, or a fully random word
    function automatic logic signed [31:0] pick_value(input int pool_pct, input bit take);
        int                 sel;
        int                 k;
        logic signed [31:0] v;
        sel = $urandom_range(0, 99);
        if (sel < pool_pct && recent_vals.size() > 0)
        begin
            k = $urandom_range(0, recent_vals.size() - 1);
            v = recent_vals[k];
            if (take)
                recent_vals.delete(k);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0, 1:    v = int'($urandom_range(0, 32)) - 16;
                2:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'sh7FFF_FFFF;
                        1:       v = 32'sh8000_0000;
                        2:       v = 32'sd0;
                        default: v = -32'sd1;
                    endcase
                end
                default: v = $urandom;
            endcase
        end
        return v;
    endfunction

    // one request transfer, then a pause unless in a back-to-back stretch;
    // start stays high across back-to-back requests so it is never dropped
    // and raised in the same step
    task automatic issue_request(input logic [1:0] m, input logic signed [31:0] v);
        sst_pkg::req_t r;
        int            gap;
        r.mode  = m;
        r.value = v;
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (m == sst_pkg::MODE_INSERT)
        begin
            recent_vals.push_back(v);
            if (recent_vals.size() > 256)
                void'(recent_vals.pop_front());
        end
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int         i;
        int         phase;
        int         sel;
        logic [1:0] m;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty set, extremes, wrapping sum, duplicates, misses,
        // removal at front, middle and end, spare mode code
        issue_request(sst_pkg::MODE_LOOKUP, 32'sd0);
        issue_request(sst_pkg::MODE_DELETE, 32'sd5);
        issue_request(MODE_SPARE, 32'sd0);
        issue_request(sst_pkg::MODE_INSERT, 32'sh7FFF_FFFF);
        issue_request(sst_pkg::MODE_INSERT, 32'sd1);           // sum wraps past max
        issue_request(sst_pkg::MODE_INSERT, 32'sh8000_0000);
        issue_request(sst_pkg::MODE_INSERT, 32'sd0);
        issue_request(sst_pkg::MODE_INSERT, -32'sd1);
        issue_request(sst_pkg::MODE_INSERT, 32'sh7FFF_FFFF);   // already held, last slot
        issue_request(sst_pkg::MODE_INSERT, 32'sh8000_0000);   // already held, first slot
        issue_request(sst_pkg::MODE_LOOKUP, 32'sh8000_0000);
        issue_request(sst_pkg::MODE_LOOKUP, 32'sh7FFF_FFFF);
        issue_request(MODE_SPARE, 32'sd1);
        issue_request(sst_pkg::MODE_LOOKUP, 32'sd2);           // absent, between entries
        issue_request(sst_pkg::MODE_DELETE, 32'sd0);
        issue_request(sst_pkg::MODE_DELETE, 32'sd0);           // already gone
        issue_request(sst_pkg::MODE_DELETE, 32'sh8000_0000);
        issue_request(sst_pkg::MODE_DELETE, 32'sh7FFF_FFFF);
        issue_request(sst_pkg::MODE_INSERT, -32'sd2);
        issue_request(sst_pkg::MODE_DELETE, -32'sd1);
        issue_request(sst_pkg::MODE_DELETE, 32'sd1);
        issue_request(sst_pkg::MODE_DELETE, -32'sd2);          // set empty again
        issue_request(sst_pkg::MODE_LOOKUP, -32'sd2);
        recent_vals.delete();

        // random: fill to full and beyond, mixed traffic, drain to empty
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase  = (i / PHASE_LEN) % 4;
            steady = ((i / 40) % 6) == 5;
            sel    = $urandom_range(0, 99);
            if (phase == PH_FILL)
                m = (sel < 80) ? sst_pkg::MODE_INSERT : (sel < 88) ? sst_pkg::MODE_DELETE :
                    (sel < 97) ? sst_pkg::MODE_LOOKUP : MODE_SPARE;
            else if (phase == PH_DRAIN)
                m = (sel < 15) ? sst_pkg::MODE_INSERT : (sel < 80) ? sst_pkg::MODE_DELETE :
                    (sel < 97) ? sst_pkg::MODE_LOOKUP : MODE_SPARE;
            else
                m = (sel < 40) ? sst_pkg::MODE_INSERT : (sel < 70) ? sst_pkg::MODE_DELETE :
                    (sel < 95) ? sst_pkg::MODE_LOOKUP : MODE_SPARE;

            case (m)
                sst_pkg::MODE_INSERT:
                    issue_request(m, pick_value((phase == PH_FILL) ? 20 : 30, 1'b0));
                sst_pkg::MODE_DELETE:
                    issue_request(m, pick_value(85, 1'b1));
                default:
                    issue_request(m, pick_value(60, 1'b0));
            endcase
        end

        // let the last result come back, then allow for one more request time
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (CAPACITY + 16) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
